// ----- design/sha_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha_pkg;

    localparam int DigestWords = 8;
    localparam int BlockWords  = 16;
    localparam int Rounds      = 64;
    localparam logic [7:0] PadMark = 8'h80;

    // Controller to compression core.
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [2:0] rd_addr;
    } core_ctl_t;

    // Compression core to controller.
    typedef struct packed {
        logic        done;
        logic [31:0] rd_data;
    } core_sts_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h6a09e667;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h428a2f98;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ----- design/sha256_stream_hash.sv -----
// Top level of the SHA-256 stream hasher: byte input stream, digest word output stream.
//
// Input stream: one transfer per message byte. s_tdata holds the byte, s_tuser[0]
// says whether it carries data, s_tlast ends the message (a flag-only transfer with
// s_tuser[0] low finalizes without a byte, so an empty message is allowed).
// Output stream: eight transfers per message, digest word 0 first; m_tuser holds
// the word position and m_tlast marks word 7.
// Data bytes are taken one per cycle while s_tready is high. Each 64th byte starts a
// compression (8 chain reads, 64 rounds at one round per cycle, 8 read-add-write
// steps on the chain RAM) while s_tready stays low, so no byte is taken until it
// is done. The end of message adds padding bytes and one or two compressions,
// then each digest word is read from the chain RAM, loaded into the output
// register and held until it is taken.
// Reset returns the chain to the initial hash, the byte and bit counts to zero.
// While m_tready is low the current word holds and no new input is taken; after
// word 7 is transferred the block starts the next message.
module sha256_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    sha_pkg::core_ctl_t core_ctl;
    sha_pkg::core_sts_t core_sts;

    logic        blk_we;
    logic [3:0]  blk_waddr;
    logic [31:0] blk_wdata;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_rdata;

    sha_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_has_byte (s_tuser[0]),
        .in_end      (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_word    (m_tdata),
        .out_index   (m_tuser),
        .out_last    (m_tlast),
        .blk_we      (blk_we),
        .blk_waddr   (blk_waddr),
        .blk_wdata   (blk_wdata),
        .core_ctl    (core_ctl),
        .core_sts    (core_sts)
    );

    // Message block, one big-endian word per entry.
    sha_ram #(.Width(32), .Depth(sha_pkg::BlockWords)) u_block_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (core_ctl),
        .sts       (core_sts),
        .blk_raddr (blk_raddr),
        .blk_rdata (blk_rdata)
    );

endmodule

// ----- design/sha_ram.sv -----
// Generic simple dual-port RAM with registered read.
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sha_core.sv -----
// SHA-256 compression core: chain value RAM, rolling schedule and round engine.
module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::core_ctl_t  ctl,
    output sha_pkg::core_sts_t  sts,
    output logic [3:0]          blk_raddr,
    input  logic [31:0]         blk_rdata
);

    typedef enum logic [1:0] {K_IDLE, K_LOAD, K_ROUND, K_ADD} kstate_t;

    kstate_t     state_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] v_reg [8];
    logic [31:0] sched_reg [16];
    logic [31:0] wk_reg;
    logic        done_reg;
    logic [7:0]  valid_reg;
    logic        rvalid_reg;
    logic [2:0]  raddr_reg;

    logic        c_we;
    logic [2:0]  c_waddr;
    logic [31:0] c_wdata;
    logic [2:0]  c_raddr;
    logic [31:0] c_rdata;
    logic [31:0] chain_q;
    logic [31:0] sched_sum;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    sha_ram #(.Width(32), .Depth(sha_pkg::DigestWords)) u_chain_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Entries not written since the last clear read as the initial hash.
    assign chain_q = rvalid_reg ? c_rdata : sha_pkg::init_hash(raddr_reg);

    always_comb
    begin
        c_raddr = ctl.rd_addr;
        if (state_reg == K_LOAD || state_reg == K_ADD)
        begin
            c_raddr = cnt_reg[2:0];
        end
        c_we    = (state_reg == K_ADD) && (cnt_reg != 7'd0);
        c_waddr = cnt_reg[2:0] - 3'd1;
        c_wdata = chain_q + v_reg[0];
    end

    // Block words are fetched in the cycle before their schedule step, through the registered RAM read.
    assign blk_raddr = (state_reg == K_ROUND) ? (cnt_reg[3:0] + 4'd1) : 4'd0;

    always_comb
    begin
        sched_sum = sha_pkg::ssig1(sched_reg[14]) + sched_reg[9]
                  + sha_pkg::ssig0(sched_reg[1]) + sched_reg[0];
        w_new = (cnt_reg[5:4] == 2'b00) ? blk_rdata : sched_sum;
        t1 = v_reg[7] + sha_pkg::bsig1(v_reg[4])
           + sha_pkg::choose(v_reg[4], v_reg[5], v_reg[6]) + wk_reg;
        t2 = sha_pkg::bsig0(v_reg[0]) + sha_pkg::major(v_reg[0], v_reg[1], v_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= K_IDLE;
            cnt_reg    <= 7'd0;
            done_reg   <= 1'b0;
            valid_reg  <= 8'd0;
            rvalid_reg <= 1'b0;
            raddr_reg  <= 3'd0;
        end
        else
        begin
            rvalid_reg <= valid_reg[c_raddr];
            raddr_reg  <= c_raddr;
            done_reg   <= 1'b0;
            if (ctl.clear)
            begin
                valid_reg <= 8'd0;
            end
            else if (c_we)
            begin
                valid_reg[c_waddr] <= 1'b1;
            end
            unique case (state_reg)
                K_IDLE:
                begin
                    cnt_reg <= 7'd0;
                    if (ctl.start)
                    begin
                        state_reg <= K_LOAD;
                    end
                end
                K_LOAD:
                begin
                    if (cnt_reg == 7'd8)
                    begin
                        state_reg <= K_ROUND;
                        cnt_reg   <= 7'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                K_ROUND:
                begin
                    if (cnt_reg == 7'(sha_pkg::Rounds))
                    begin
                        state_reg <= K_ADD;
                        cnt_reg   <= 7'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                K_ADD:
                begin
                    if (cnt_reg == 7'd8)
                    begin
                        state_reg <= K_IDLE;
                        cnt_reg   <= 7'd0;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                default:
                begin
                    state_reg <= K_IDLE;
                end
            endcase
        end
    end

    // Working variables, schedule window and the precomputed W+K.
    always_ff @(posedge clk)
    begin
        if ((state_reg == K_LOAD || state_reg == K_ADD) && cnt_reg != 7'd0)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i + 1];
            end
            v_reg[7] <= chain_q;
        end
        else if (state_reg == K_ROUND && cnt_reg != 7'd0)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == K_ROUND && !cnt_reg[6])
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= w_new;
            wk_reg <= w_new + sha_pkg::round_const(cnt_reg[5:0]);
        end
    end

    assign sts.done    = done_reg;
    assign sts.rd_data = chain_q;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> state_reg == K_IDLE)
        else $error("compression start while core busy");
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        c_we |-> c_waddr != c_raddr)
        else $error("chain read and write collide");
`endif

endmodule

// ----- design/sha_ctrl.sv -----
// Byte gathering, padding sequencer, bit count and digest output of the hasher.
module sha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_has_byte,
    input  logic                in_end,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_word,
    output logic [2:0]          out_index,
    output logic                out_last,
    output logic                blk_we,
    output logic [3:0]          blk_waddr,
    output logic [31:0]         blk_wdata,
    output sha_pkg::core_ctl_t  core_ctl,
    input  sha_pkg::core_sts_t  core_sts
);

    typedef enum logic [2:0] {
        C_IDLE, C_PAD, C_COMP, C_EMIT_RD, C_EMIT_LD, C_EMIT_WAIT
    } cstate_t;

    cstate_t     state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bit_count_reg;
    logic [23:0] gath_reg;
    logic        pad_active_reg;
    logic        pad_first_reg;
    logic        len_ok_reg;
    logic        final_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;

    logic        push;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic [63:0] count_shift;
    logic        full;
    logic        in_xfer;
    logic        last_taken;

    assign in_ready   = (state_reg == C_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign full       = (fill_reg == 6'd63);
    assign last_taken = (state_reg == C_EMIT_WAIT) && out_ready
                     && (idx_reg == 3'(sha_pkg::DigestWords - 1));

    // Length bytes go big-endian into the last eight bytes of the block.
    assign count_shift = bit_count_reg << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        priority if (pad_first_reg)
        begin
            pad_byte = sha_pkg::PadMark;
        end
        else if (len_ok_reg && fill_reg[5:3] == 3'b111)
        begin
            pad_byte = count_shift[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign push      = (in_xfer && in_has_byte) || (state_reg == C_PAD);
    assign push_byte = (state_reg == C_PAD) ? pad_byte : in_byte;

    assign blk_we    = push && (fill_reg[1:0] == 2'b11);
    assign blk_waddr = fill_reg[5:2];
    assign blk_wdata = {gath_reg, push_byte};

    assign core_ctl.start   = push && full;
    assign core_ctl.clear   = last_taken;
    assign core_ctl.rd_addr = idx_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            gath_reg <= {gath_reg[15:0], push_byte};
        end
        if (state_reg == C_EMIT_LD)
        begin
            out_word_reg <= core_sts.rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= C_IDLE;
            fill_reg       <= 6'd0;
            bit_count_reg  <= 64'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_ok_reg     <= 1'b0;
            final_reg      <= 1'b0;
            idx_reg        <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            unique case (state_reg)
                C_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_has_byte)
                        begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                        end
                        if (in_end)
                        begin
                            pad_active_reg <= 1'b1;
                            pad_first_reg  <= 1'b1;
                            len_ok_reg     <= 1'b0;
                            final_reg      <= 1'b0;
                        end
                        priority if (in_has_byte && full)
                        begin
                            state_reg <= C_COMP;
                        end
                        else if (in_end)
                        begin
                            state_reg <= C_PAD;
                        end
                        else
                        begin
                            state_reg <= C_IDLE;
                        end
                    end
                end
                C_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    // Length fits only if the mark lands before the last eight bytes.
                    if ((pad_first_reg && fill_reg[5:3] != 3'b111) || full)
                    begin
                        len_ok_reg <= 1'b1;
                    end
                    if (full)
                    begin
                        final_reg <= len_ok_reg;
                        state_reg <= C_COMP;
                    end
                end
                C_COMP:
                begin
                    if (core_sts.done)
                    begin
                        priority if (final_reg)
                        begin
                            state_reg <= C_EMIT_RD;
                        end
                        else if (pad_active_reg)
                        begin
                            state_reg <= C_PAD;
                        end
                        else
                        begin
                            state_reg <= C_IDLE;
                        end
                    end
                end
                C_EMIT_RD:
                begin
                    state_reg <= C_EMIT_LD;
                end
                C_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= C_EMIT_WAIT;
                end
                C_EMIT_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        idx_reg       <= idx_reg + 3'd1;
                        if (last_taken)
                        begin
                            bit_count_reg  <= 64'd0;
                            pad_active_reg <= 1'b0;
                            final_reg      <= 1'b0;
                            state_reg      <= C_IDLE;
                        end
                        else
                        begin
                            state_reg <= C_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 3'(sha_pkg::DigestWords - 1));

`ifndef SYNTH
    a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        core_sts.done |-> state_reg == C_COMP)
        else $error("compression done outside of a compression wait");
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == C_EMIT_WAIT && fill_reg == 6'd0)
        else $error("digest word shown outside of output phase");
    a_final_padding: assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> pad_active_reg)
        else $error("final block flagged outside of padding");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the SHA-256 stream hasher: byte stream in, digest words out.

localparam bit [7:0] PAD_BYTE = 8'h80;
localparam int QUIET_LIMIT = 3000;
localparam int DRAIN_CYCLES = 100;

localparam bit [255:0] START_CHAIN = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

localparam bit [2047:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
} digest_word_t;

class digest_board;
    bit [31:0]    chain[8];
    bit [7:0]     block[64];
    int unsigned  fill;
    bit [63:0]    bit_total;
    digest_word_t expected_digest[$];
    int           fail_count;

    function new();
        fail_count = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++)
            chain[i] = START_CHAIN[(7 - i) * 32 +: 32];
        fill = 0;
        bit_total = '0;
    endfunction

    static function bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        bit [31:0] w[64];
        bit [31:0] v[8];
        bit [31:0] t1;
        bit [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = {block[4 * t], block[4 * t + 1], block[4 * t + 2], block[4 * t + 3]};
        for (int t = 16; t < 64; t++)
            w[t] = (rotr(w[t - 2], 17) ^ rotr(w[t - 2], 19) ^ (w[t - 2] >> 10)) + w[t - 7]
                 + (rotr(w[t - 15], 7) ^ rotr(w[t - 15], 18) ^ (w[t - 15] >> 3)) + w[t - 16];
        v = chain;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[(63 - t) * 32 +: 32] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] += v[i];
    endfunction

    // Called once per accepted input transfer.
    function void take_byte_item(bit [7:0] data, bit has_byte, bit eom);
        int unsigned n;
        if (has_byte)
        begin
            block[fill] = data;
            fill++;
            bit_total += 64'd8;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        end
        if (!eom)
            return;
        block[fill] = PAD_BYTE;
        n = fill + 1;
        // no room for the length field: pad out and spill into a second block
        if (n > 56)
        begin
            for (int i = n; i < 64; i++)
                block[i] = 8'h00;
            compress();
            n = 0;
        end
        for (int i = n; i < 56; i++)
            block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            block[56 + i] = bit_total[63 - 8 * i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
            expected_digest.push_back('{chain[i], i[2:0], i == 7});
        restart();
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    task check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
        digest_word_t want;
        if (expected_digest.size() == 0)
        begin
            report($sformatf("unexpected digest word %08h index %0d last %0d", word, index, last));
            return;
        end
        want = expected_digest.pop_front();
        if (word !== want.word || index !== want.index || last !== want.last)
            report($sformatf("digest word got %08h/%0d/%0d want %08h/%0d/%0d",
                             word, index, last, want.word, want.index, want.last));
    endtask
endclass

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    bit          steady = 1'b0;   // suppresses idling on both sides
    int          quiet_cycles = 0;
    digest_board board = new();

    sha256_stream_hash dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 31);

    // Everything changes on the rising edge, so the falling edge sees what the
    // next rising edge will sample.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_digest_word(m_tdata, m_tuser, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Entered and left at a rising edge; valid stays up between back-to-back transfers.
    task automatic send_item(input bit [7:0] data, input bit has_byte, input bit eom);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= eom;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        board.take_byte_item(data, has_byte, eom);
        @(posedge clk);
    endtask

    // Returns the number of counted items sent (noise excluded).
    task automatic send_message(input int len, output int sent);
        bit end_on_byte;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        sent = 0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
            sent++;
        end
        if (!end_on_byte)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
            sent++;
        end
    endtask

    initial
    begin
        int items;
        int sent;
        int msg_count;
        int len;
        int pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then an ignored item
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        // "abc" with end on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b1);

        items = 0;
        msg_count = 0;
        while (items < 280)
        begin
            steady = (msg_count == 1 || msg_count == 2);
            pick = $urandom_range(0, 9);
            // first messages hit the padding boundaries: one final block,
            // two final blocks, and an exact full block
            if (msg_count == 0)
                len = 55;
            else if (msg_count == 1)
                len = 56;
            else if (msg_count == 2)
                len = 64;
            else if (pick < 6)
                len = $urandom_range(0, 12);
            else if (pick < 8)
                len = $urandom_range(52, 66);
            else if (pick < 9)
                len = $urandom_range(118, 130);
            else
                len = $urandom_range(0, 40);
            send_message(len, sent);
            items += sent;
            msg_count++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (board.expected_digest.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.expected_digest.size() != 0)
            board.report($sformatf("%0d digest words never arrived",
                                   board.expected_digest.size()));
        if (board.fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
design/sha_pkg.sv
design/sha_ram.sv
design/sha_core.sv
design/sha_ctrl.sv
design/sha256_stream_hash.sv
sim/tb.sv
